[src/assert_macros.svh]
// Assertion macros shared by the windowed content match RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

[src/wcm_pkg.sv]
`timescale 1ns / 1ps
// Package for the windowed content match unit: sizes, payload and
// configuration types, register indexes and the case folding function.
package wcm_pkg;

  localparam int PATTERN_MAX    = 8;
  localparam int POSITION_WIDTH = 16;
  localparam int LEN_W          = $clog2(PATTERN_MAX + 1);
  localparam int PAT_IDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int SPAN_W         = 16;
  localparam int CFG_DATA_W     = 64;

  // anchor_flags bit positions
  localparam int ANCHOR_OFFSET   = 0;
  localparam int ANCHOR_DEPTH    = 1;
  localparam int ANCHOR_DISTANCE = 2;
  localparam int ANCHOR_WITHIN   = 3;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_GAP = 8'h20;

  typedef enum logic [2:0] {
    REG_PATTERN_BYTES    = 3'd0,
    REG_PATTERN_LENGTH   = 3'd1,
    REG_CASE_INSENSITIVE = 3'd2,
    REG_ANCHOR_FLAGS     = 3'd3,
    REG_START_OFFSET     = 3'd4,
    REG_DEPTH_SPAN       = 3'd5,
    REG_DISTANCE_GAP     = 3'd6,
    REG_WITHIN_SPAN      = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [7:0]                data_byte;
    logic                      last_byte;
    logic [POSITION_WIDTH-1:0] prior_end;
  } item_t;

  typedef struct packed {
    logic                      found;
    logic [POSITION_WIDTH-1:0] end_pos;
  } result_t;

  // Window bound settings seen by the position tracker
  typedef struct packed {
    logic [LEN_W-1:0]  pattern_length;
    logic [3:0]        anchor_flags;
    logic [SPAN_W-1:0] start_offset;
    logic [SPAN_W-1:0] depth_span;
    logic [SPAN_W-1:0] distance_gap;
    logic [SPAN_W-1:0] within_span;
  } bounds_cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    if (en && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      return b + ASCII_CASE_GAP;
    end
    return b;
  endfunction

endpackage

[src/wcm_cell.sv]
`timescale 1ns / 1ps
// One cell of the byte window chain: holds one buffer byte and compares the
// byte it is taking in against its pattern byte. Uses wcm_pkg.
module wcm_cell import wcm_pkg::*; (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  output logic [7:0] byte_out,
  input  logic [7:0] pat_byte,
  input  logic       fold_en,
  input  logic       active,
  output logic       match
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  // An unused cell never blocks a match
  assign match = !active || (fold_byte(byte_in, fold_en) == fold_byte(pat_byte, fold_en));

endmodule

[src/wcm_tracker.sv]
`timescale 1ns / 1ps
// Position tracker: byte counter, window bound check and first hit capture
// for one buffer. Uses wcm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wcm_tracker import wcm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      last_byte,
  input  logic [POSITION_WIDTH-1:0] prior_end,
  input  logic                      all_match,
  input  bounds_cfg_t               cfg,
  output result_t                   result
);

  localparam int W = POSITION_WIDTH + 1;
  localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

  logic [POSITION_WIDTH-1:0] byte_position, byte_position_next;
  logic                      hit_seen, hit_seen_next;
  logic [POSITION_WIDTH-1:0] first_end, first_end_next;

  logic          can_take;
  logic [W-1:0]  pos_end, len_w, first_pos, start_pos, prev_w, dbase;
  logic          len_ok, within_ok, depth_ok, hit, new_hit;

  always_comb begin
    can_take  = byte_position != PosMax;
    pos_end   = {1'b0, byte_position} + W'(1);
    len_w     = W'(cfg.pattern_length);
    len_ok    = (cfg.pattern_length != '0) && (cfg.pattern_length <= LEN_W'(PATTERN_MAX));
    first_pos = pos_end - len_w;
    prev_w    = W'(prior_end);

    priority if (cfg.anchor_flags[ANCHOR_DISTANCE]) begin
      start_pos = prev_w + W'(cfg.distance_gap);
    end else if (cfg.anchor_flags[ANCHOR_OFFSET]) begin
      start_pos = W'(cfg.start_offset);
    end else begin
      start_pos = prev_w;
    end

    dbase     = cfg.anchor_flags[ANCHOR_OFFSET] ? W'(cfg.start_offset) : '0;
    within_ok = !(cfg.anchor_flags[ANCHOR_WITHIN] &&
                  (prev_w + W'(cfg.within_span) < pos_end));
    depth_ok  = !(cfg.anchor_flags[ANCHOR_DEPTH] &&
                  (dbase + W'(cfg.depth_span) < pos_end));

    hit     = len_ok && (pos_end >= len_w) && (first_pos >= start_pos) &&
              within_ok && depth_ok && all_match;
    new_hit = can_take && !hit_seen && hit;

    result.found   = hit_seen || new_hit;
    result.end_pos = hit_seen ? first_end :
                     (new_hit ? pos_end[POSITION_WIDTH-1:0] : '0);

    byte_position_next = byte_position;
    hit_seen_next      = hit_seen;
    first_end_next     = first_end;
    if (accept) begin
      if (last_byte) begin
        byte_position_next = '0;
        hit_seen_next      = 1'b0;
        first_end_next     = '0;
      end else begin
        if (new_hit) begin
          hit_seen_next  = 1'b1;
          first_end_next = pos_end[POSITION_WIDTH-1:0];
        end
        if (can_take) begin
          byte_position_next = byte_position + POSITION_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      hit_seen      <= 1'b0;
      first_end     <= '0;
    end else begin
      byte_position <= byte_position_next;
      hit_seen      <= hit_seen_next;
      first_end     <= first_end_next;
    end
  end

  `ASSERT_PROP(a_clear_after_last, clk, rst, accept && last_byte |=> byte_position == '0 && !hit_seen)
  `ASSERT_NEVER(a_hit_end_valid, clk, rst, hit_seen && (first_end == '0 || first_end > byte_position))
  `ASSERT_PROP(a_position_advances, clk, rst, accept && !last_byte && can_take |=> byte_position == $past(byte_position) + POSITION_WIDTH'(1))

endmodule

[src/windowed_content_match_unit.sv]
`timescale 1ns / 1ps
// Windowed content match unit: one buffer byte per cycle, answer on last byte.
// The result is registered and valid in the cycle after the last byte's transfer.
// Throughput: one byte per cycle, one answer per buffer; a last byte waits only
// while the previous answer is still held by a stalled result port.
// Reset (synchronous, rst high): registers to defaults, counters cleared,
// no result pending. Uses wcm_pkg, wcm_cell, wcm_tracker, assert_macros.svh.
`include "assert_macros.svh"
module windowed_content_match_unit import wcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // byte stream
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  // result stream
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  reg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [PATTERN_MAX-1:0][7:0] pattern_bytes;
  logic [LEN_W-1:0]            pattern_length;
  logic                        case_insensitive;
  logic [3:0]                  anchor_flags;
  logic [SPAN_W-1:0]           start_offset;
  logic [SPAN_W-1:0]           depth_span;
  logic [SPAN_W-1:0]           distance_gap;
  logic [SPAN_W-1:0]           within_span;

  logic                        item_accept;
  logic [PATTERN_MAX-1:0][7:0] chain_in;
  logic [PATTERN_MAX-1:0]      cell_match;
  bounds_cfg_t                 bounds_cfg;
  result_t                     tracker_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes    <= '0;
      pattern_length   <= LEN_W'(1);
      case_insensitive <= 1'b0;
      anchor_flags     <= '0;
      start_offset     <= '0;
      depth_span       <= '0;
      distance_gap     <= '0;
      within_span      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:    pattern_bytes    <= cfg_data[PATTERN_MAX*8-1:0];
        REG_PATTERN_LENGTH:   pattern_length   <= cfg_data[LEN_W-1:0];
        REG_CASE_INSENSITIVE: case_insensitive <= cfg_data[0];
        REG_ANCHOR_FLAGS:     anchor_flags     <= cfg_data[3:0];
        REG_START_OFFSET:     start_offset     <= cfg_data[SPAN_W-1:0];
        REG_DEPTH_SPAN:       depth_span       <= cfg_data[SPAN_W-1:0];
        REG_DISTANCE_GAP:     distance_gap     <= cfg_data[SPAN_W-1:0];
        REG_WITHIN_SPAN:      within_span      <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold only a last byte while a result still waits: every other byte
  // produces nothing and may pass straight through.
  assign item_stall  = result_valid && result_stall && item.last_byte;
  assign item_accept = item_valid && !item_stall;

  // Byte window: cell 0 takes the new byte, each cell hands its byte on to
  // the next. Cell k compares the byte it takes in (the window entry k after
  // the shift) against pattern byte length-1-k.
  assign chain_in[0] = item.data_byte;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    localparam logic [LEN_W-1:0] CellIdx = LEN_W'(k);
    logic             active;
    logic [LEN_W-1:0] pat_sel;

    assign active  = CellIdx < pattern_length;
    assign pat_sel = pattern_length - CellIdx - LEN_W'(1);

    if (k < PATTERN_MAX - 1) begin : g_link
      wcm_cell u_cell (
        .clk      (clk),
        .shift_en (item_accept),
        .byte_in  (chain_in[k]),
        .byte_out (chain_in[k+1]),
        .pat_byte (pattern_bytes[pat_sel[PAT_IDX_W-1:0]]),
        .fold_en  (case_insensitive),
        .active   (active),
        .match    (cell_match[k])
      );
    end else begin : g_tail
      // The tail cell's held byte is never needed again: drop it
      wcm_cell u_cell (
        .clk      (clk),
        .shift_en (item_accept),
        .byte_in  (chain_in[k]),
        .byte_out (),
        .pat_byte (pattern_bytes[pat_sel[PAT_IDX_W-1:0]]),
        .fold_en  (case_insensitive),
        .active   (active),
        .match    (cell_match[k])
      );
    end
  end

  assign bounds_cfg = '{
    pattern_length: pattern_length,
    anchor_flags:   anchor_flags,
    start_offset:   start_offset,
    depth_span:     depth_span,
    distance_gap:   distance_gap,
    within_span:    within_span
  };

  wcm_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .accept    (item_accept),
    .last_byte (item.last_byte),
    .prior_end (item.prior_end),
    .all_match (&cell_match),
    .cfg       (bounds_cfg),
    .result    (tracker_result)
  );

  // Output register: load on a last byte's transfer, drop once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_accept && item.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && item.last_byte) begin
      result <= tracker_result;
    end
  end

  `ASSERT_PROP(a_last_gives_result, clk, rst, item_accept && item.last_byte |=> result_valid)
  `ASSERT_NEVER(a_no_overwrite, clk, rst, item_accept && item.last_byte && result_valid && result_stall)
  `ASSERT_PROP(a_miss_has_zero_end, clk, rst, result_valid && !result.found |-> result.end_pos == '0)

endmodule
